[sv/bcm_pkg.sv]
// Shared constants for the binomial coefficient modulo core.
package bcm_pkg;
	localparam int N_MAX_DEF = 1024;
	localparam int N_W = 11;
	localparam int COEFF_W = 30;
	localparam logic [COEFF_W-1:0] MOD_RESET = 30'd1000000007;
endpackage

[sv/bcm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bcm_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 513
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/binomial_coefficient_mod_core.sv]
// Binomial coefficient C(n, r) modulo a programmable modulus, Pascal row recurrence.
//
// Each query word (n, r) gives one result word. r is folded to min(r, n - r) and the
// coefficient is built row by row in a RAM of N_MAX/2 + 1 entries, one modular add per
// cycle within a row through a single adder/compare/subtract unit fed by the RAM read
// port. Each row is followed by the gap state ST_GAP. r above n, n above N_MAX, a zero
// modulus and r of zero skip the rows and go straight to ST_FINISH. A finished query
// also waits while the output register holds an unaccepted word. The input is not ready
// while a query is in work; a finished word waits in the output register while the next
// query is taken. The modulus must be written only while the core is idle; the core
// itself does not enforce this.
module binomial_coefficient_mod_core
	import bcm_pkg::*;
#(
	parameter int N_MAX = N_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COEFF_W-1:0] cfg_wdata,       // modulus
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [23:0]        s_axis_tdata,    // [10:0] n_value, [21:11] r_value
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [31:0]        m_axis_tdata,    // [29:0] coeff
	output logic               m_axis_tuser     // [0] out_of_range
);
	localparam int DEPTH = N_MAX / 2 + 1;
	localparam int AW = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ROW    = 2'd1;
	localparam logic [1:0] ST_GAP    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]         state_q;
	logic [COEFF_W-1:0] mod_q;
	logic [N_W-1:0]     n_q;
	logic [N_W-1:0]     i_q;
	logic [AW-1:0]      r_q;
	logic [AW-1:0]      k_q;
	logic               first_q;
	logic               load_q;
	logic [COEFF_W-1:0] hi_q;
	logic [COEFF_W-1:0] res_q;
	logic               oor_q;

	logic               vld_s1;
	logic [AW-1:0]      k_s1;
	logic               first_s1;
	logic               load_s1;

	logic               out_vld_q;
	logic [COEFF_W-1:0] out_coeff_q;
	logic               out_oor_q;

	logic [N_W-1:0]     n_in, r_in, nmr, rmin;
	logic               in_fire, in_oor, in_rgt;
	logic               in_zero, in_short, row_start, fin_load;
	logic [COEFF_W-1:0] one_m;
	logic [N_W-1:0]     next_i;
	logic               row_le;
	logic [AW-1:0]      row_k;

	logic [COEFF_W-1:0] ram_rdata, lo, hi_eff, sum_mod;
	logic [COEFF_W:0]   sum;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               out_free;

	assign n_in    = s_axis_tdata[10:0];
	assign r_in    = s_axis_tdata[21:11];
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign in_oor  = 32'(n_in) > N_MAX;
	assign in_rgt  = r_in > n_in;
	assign nmr     = n_in - r_in;
	assign rmin    = (nmr < r_in) ? nmr : r_in;
	assign one_m   = (mod_q == COEFF_W'(1)) ? '0 : COEFF_W'(1);

	assign in_zero  = in_oor || in_rgt || mod_q == '0;
	assign in_short = in_zero || rmin == '0;
	// row setup on entry to a row
	assign row_start = (state_q == ST_IDLE && in_fire && !in_short)
		|| (state_q == ST_GAP && i_q != n_q);
	assign fin_load  = (state_q == ST_FINISH) && out_free;

	assign next_i  = (state_q == ST_IDLE) ? N_W'(1) : i_q + N_W'(1);
	assign row_le  = 32'(next_i) <= 32'(r_q);
	assign row_k   = row_le ? AW'(next_i - N_W'(1)) : r_q;

	bcm_ram #(.WIDTH(COEFF_W), .DEPTH(DEPTH)) u_row (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (sum_mod),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	// entry 0 of every row is the constant one
	assign lo        = (k_s1 == '0) ? one_m : ram_rdata;
	assign hi_eff    = first_s1 ? '0 : hi_q;
	assign sum       = {1'b0, hi_eff} + {1'b0, lo};
	assign sum_mod   = (sum >= {1'b0, mod_q}) ? COEFF_W'(sum - {1'b0, mod_q}) : sum[COEFF_W-1:0];
	assign ram_we    = vld_s1 && !load_s1;
	assign ram_waddr = k_s1 + AW'(1);

	assign out_free  = !out_vld_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_coeff_q};
	assign m_axis_tuser  = out_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mod_q     <= MOD_RESET;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			first_q   <= 1'b0;
			load_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_ROW);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= in_short ? ST_FINISH : ST_ROW;
					end
				end
				ST_ROW: begin
					if (k_q == '0) begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					state_q <= (i_q == n_q) ? ST_FINISH : ST_ROW;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (row_start) begin
				first_q <= 1'b1;
				load_q  <= (state_q == ST_IDLE) ? 1'b0 : !row_le;
			end else if (state_q == ST_ROW) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			n_q   <= n_in;
			r_q   <= AW'(rmin);
			oor_q <= in_oor;
			res_q <= (!in_zero && rmin == '0) ? one_m : '0;
		end else if (vld_s1 && !load_s1 && i_q == n_q && ram_waddr == r_q) begin
			res_q <= sum_mod;
		end
		if (row_start) begin
			i_q <= next_i;
		end
		// first row: i = 1 <= r, read entry 0 only
		if (state_q == ST_ROW) begin
			k_q <= k_q - AW'(1);
		end else if (state_q == ST_GAP) begin
			k_q <= row_k;
		end else begin
			k_q <= '0;
		end
		if (state_q == ST_ROW) begin
			k_s1     <= k_q;
			first_s1 <= first_q;
			load_s1  <= load_q && first_q;
		end
		if (vld_s1) begin
			hi_q <= lo;
		end
		if (fin_load) begin
			out_coeff_q <= res_q;
			out_oor_q   <= oor_q;
		end
	end

	a_no_write_row0: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr != '0)
		else $error("write to constant entry 0");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr <= r_q)
		else $error("row write beyond r");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out of range result with nonzero coeff");

	a_coeff_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mod_q != '0 |-> m_axis_tdata[COEFF_W-1:0] < mod_q)
		else $error("coeff not reduced");

	a_pipe_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_ROW || state_q == ST_GAP)
		else $error("row pipeline active outside a row");
endmodule
